/* rtl/core/assert_macros.svh */
// Assertion macros used by the port-level checker of the matrix multiply unit.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// The consequent must hold in the cycle after the antecedent.
`define MM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

/* rtl/core/mm_pkg.sv */
// Package for the matrix multiply unit: sizes, payload structs, codes and the
// sequencer state type. Depends on nothing.
package mm_pkg;

    localparam int MAX_DIM   = 32;
    localparam int IDX_W     = $clog2(MAX_DIM);
    localparam int DIM_W     = $clog2(MAX_DIM + 1);
    localparam int ADDR_W    = 2 * IDX_W;
    localparam int DEPTH     = MAX_DIM * MAX_DIM;
    localparam int FIELD_W   = 5;
    localparam int VALUE_W   = 16;
    localparam int PROD_W    = 2 * VALUE_W;
    localparam int SUM_W     = 48;
    localparam int CFG_W     = 6;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [1:0] {
        ACT_LOAD_LEFT  = 2'd0,
        ACT_LOAD_RIGHT = 2'd1,
        ACT_COMPUTE    = 2'd2,
        ACT_UNUSED     = 2'd3
    } action_t;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS_A    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_DIM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_B    = 2'd2;

    typedef struct packed {
        logic [1:0]                action;
        logic [FIELD_W-1:0]        row;
        logic [FIELD_W-1:0]        col;
        logic signed [VALUE_W-1:0] value;
    } item_t;

    typedef struct packed {
        logic [FIELD_W-1:0]      out_row;
        logic [FIELD_W-1:0]      out_col;
        logic signed [SUM_W-1:0] sum;
        logic                    last;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DRAIN,
        ST_EMIT
    } mm_state_t;

    // A dimension register of zero acts as one, above MAX_DIM acts as MAX_DIM.
    function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] r);
        logic [DIM_W-1:0] d;
        if (r == '0)
        begin
            d = DIM_W'(1);
        end
        else if (32'(r) > MAX_DIM)
        begin
            d = DIM_W'(MAX_DIM);
        end
        else
        begin
            d = DIM_W'(r);
        end
        return d;
    endfunction

endpackage

/* rtl/core/matrix_multiply_unit.sv */
// Matrix multiply unit top level: operand stores, one shared multiply-accumulate
// and the sequencer that walks a product row. Depends on mm_pkg.
// A compute item with a row below rows_a emits one sum per column of B, each after its inner_dim
// products are accumulated and the pipeline drains; item_ready stays low until the row is done.
// Throughput is set by the single MAC, fed one operand pair per cycle from the stores while in ST_READ.
// Reset clears the sequencer and sets all three dimension registers to 1; stores are not cleared.
module matrix_multiply_unit
    import mm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  item_t                item,
    output logic                 result_valid,
    input  logic                 result_ready,
    output result_t              result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    logic [VALUE_W-1:0] left_mem  [DEPTH];
    logic [VALUE_W-1:0] right_mem [DEPTH];

    mm_state_t                 state_reg, state_next;
    logic [CFG_W-1:0]          rows_a_reg, inner_dim_reg, cols_b_reg;
    logic [IDX_W-1:0]          row_reg, row_next;
    logic [IDX_W-1:0]          j_reg, j_next;
    logic [IDX_W-1:0]          k_reg, k_next;
    logic signed [SUM_W-1:0]   acc_reg, acc_next;
    logic signed [VALUE_W-1:0] left_rd_reg, right_rd_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic                      rd_vld_reg, prod_vld_reg;
    result_t                   result_reg;
    logic                      result_valid_reg;

    logic [DIM_W-1:0]  na, nk, nb;
    logic              item_xfer, start, left_we, right_we;
    logic              issue, emit, slot_free, k_last, j_last;
    logic [ADDR_W-1:0] wr_addr, left_rd_addr, right_rd_addr;

    assign na = eff_dim(rows_a_reg);
    assign nk = eff_dim(inner_dim_reg);
    assign nb = eff_dim(cols_b_reg);

    assign item_xfer = item_valid && item_ready;
    assign slot_free = !result_valid_reg || result_ready;
    assign k_last    = (32'(k_reg) + 1 == 32'(nk));
    assign j_last    = (32'(j_reg) + 1 == 32'(nb));

    assign wr_addr       = {IDX_W'(item.row), IDX_W'(item.col)};
    assign left_rd_addr  = {row_reg, k_reg};
    assign right_rd_addr = {k_reg, j_reg};

    // Control outputs of the sequencer.
    always_comb
    begin
        item_ready = (state_reg == ST_IDLE);
        issue      = (state_reg == ST_READ);
        emit       = (state_reg == ST_EMIT) && slot_free;
        left_we    = item_xfer && (item.action == ACT_LOAD_LEFT)
                     && (32'(item.row) < 32'(na)) && (32'(item.col) < 32'(nk));
        right_we   = item_xfer && (item.action == ACT_LOAD_RIGHT)
                     && (32'(item.row) < 32'(nk)) && (32'(item.col) < 32'(nb));
        start      = item_xfer && (item.action == ACT_COMPUTE)
                     && (32'(item.row) < 32'(na));
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (k_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!rd_vld_reg && !prod_vld_reg)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    state_next = j_last ? ST_IDLE : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Counters and accumulator.
    always_comb
    begin
        row_next = row_reg;
        j_next   = j_reg;
        k_next   = k_reg;
        acc_next = acc_reg;
        if (prod_vld_reg)
        begin
            acc_next = acc_reg + {{(SUM_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        end
        if (start)
        begin
            row_next = IDX_W'(item.row);
            j_next   = '0;
            k_next   = '0;
            acc_next = '0;
        end
        else if (issue)
        begin
            k_next = k_reg + IDX_W'(1);
        end
        else if (emit)
        begin
            j_next   = j_reg + IDX_W'(1);
            k_next   = '0;
            acc_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            rows_a_reg       <= CFG_W'(1);
            inner_dim_reg    <= CFG_W'(1);
            cols_b_reg       <= CFG_W'(1);
            rd_vld_reg       <= 1'b0;
            prod_vld_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_vld_reg   <= issue;
            prod_vld_reg <= rd_vld_reg;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_ROWS_A:    rows_a_reg    <= cfg_data;
                    REG_INNER_DIM: inner_dim_reg <= cfg_data;
                    REG_COLS_B:    cols_b_reg    <= cfg_data;
                    default:       ;
                endcase
            end
            if (emit)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers carry no reset.
    always_ff @(posedge clk)
    begin
        row_reg  <= row_next;
        j_reg    <= j_next;
        k_reg    <= k_next;
        acc_reg  <= acc_next;
        prod_reg <= left_rd_reg * right_rd_reg;
        if (emit)
        begin
            result_reg.out_row <= FIELD_W'(row_reg);
            result_reg.out_col <= FIELD_W'(j_reg);
            result_reg.sum     <= acc_reg;
            result_reg.last    <= j_last;
        end
    end

    // Operand stores, one write port and one registered read port each.
    always_ff @(posedge clk)
    begin
        if (left_we)
        begin
            left_mem[wr_addr] <= item.value;
        end
        left_rd_reg <= left_mem[left_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (right_we)
        begin
            right_mem[wr_addr] <= item.value;
        end
        right_rd_reg <= right_mem[right_rd_addr];
    end

    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

/* rtl/core/mm_checker.sv */
// Port-level checker for the matrix multiply unit, bound to the top level.
// Depends on mm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mm_checker
    import mm_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    item_valid,
    input logic    item_ready,
    input item_t   item,
    input logic    result_valid,
    input logic    result_ready,
    input result_t result
);

    // A stalled result holds its payload.
    `MM_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && !result_ready, $stable(result))

    // A result only appears after the unit has been busy.
    `MM_ASSERT_NOW(a_result_after_busy, clk, rst_n, $rose(result_valid), $past(!item_ready))

    // A result that is not the last of its row appears while the unit is still busy.
    `MM_ASSERT_NOW(a_busy_mid_row, clk, rst_n, $rose(result_valid) && !result.last, !item_ready)

    // Loads and unused actions never take the unit out of idle.
    `MM_ASSERT_NEXT(a_load_stays_idle, clk, rst_n,
        item_valid && item_ready && item.action != ACT_COMPUTE, item_ready)

endmodule

bind matrix_multiply_unit mm_checker u_mm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);
